### rtl/sfr_pkg.sv
// sfr_pkg: shared types, register indexes, match modes and the character
// class test for the stream find-and-replace block. No dependencies.
`default_nettype none

package sfr_pkg;

  typedef logic [7:0] byte_t;

  // Input transfer and result transfer payloads.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        end_of_stream;
    logic [15:0] match_total;
  } out_item_t;

  // Configuration port: 64-bit registers at byte address 8*index.
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_MATCH_MODE     = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_PATTERN_BYTES  = 3'd2,
    REG_REPLACE_LENGTH = 3'd3,
    REG_REPLACE_BYTES  = 3'd4
  } reg_index_t;

  // Match modes.
  localparam logic [3:0] MODE_LITERAL  = 4'd0;
  localparam logic [3:0] MODE_BLANK    = 4'd1;
  localparam logic [3:0] MODE_DIGIT    = 4'd2;
  localparam logic [3:0] MODE_LETTER   = 4'd3;
  localparam logic [3:0] MODE_LOWER    = 4'd4;
  localparam logic [3:0] MODE_UPPER    = 4'd5;
  localparam logic [3:0] MODE_ALNUM    = 4'd6;
  localparam logic [3:0] MODE_ASCII    = 4'd7;
  localparam logic [3:0] MODE_NOTASCII = 4'd8;
  localparam logic [3:0] MODE_HIGH     = 4'd9;

  // Character constants.
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_LOW_A = 8'h61;
  localparam byte_t CH_LOW_Z = 8'h7A;
  localparam byte_t CH_UP_A  = 8'h41;
  localparam byte_t CH_UP_Z  = 8'h5A;
  localparam byte_t CH_HIGH  = 8'h80;

  // Control handed to every window cell.
  typedef struct packed {
    logic accept;  // an input transfer takes place this cycle
    logic shift;   // the oldest byte leaves the window
  } cell_ctrl_t;

  // Per-run information that goes with the emitted bytes.
  typedef struct packed {
    logic        marker;  // end marker carrying no byte
    logic        last;    // run closes the stream
    logic [15:0] total;
  } run_flags_t;

  function automatic logic class_hit(input logic [3:0] mode, input byte_t b);
    logic blank, digit, lower, upper, ascii;
    blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    lower = (b >= CH_LOW_A) && (b <= CH_LOW_Z);
    upper = (b >= CH_UP_A) && (b <= CH_UP_Z);
    ascii = ((b > CH_SPACE) && (b < CH_HIGH)) || blank;
    case (mode)
      MODE_BLANK:    class_hit = blank;
      MODE_DIGIT:    class_hit = digit;
      MODE_LETTER:   class_hit = lower || upper;
      MODE_LOWER:    class_hit = lower;
      MODE_UPPER:    class_hit = upper;
      MODE_ALNUM:    class_hit = lower || upper || digit;
      MODE_ASCII:    class_hit = ascii;
      MODE_NOTASCII: class_hit = !ascii;
      MODE_HIGH:     class_hit = (b >= CH_HIGH);
      default:       class_hit = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/sfr_cell.sv
// sfr_cell: one slot of the sliding match window, holding a byte and
// comparing it with its pattern byte. Depends on sfr_pkg.
`default_nettype none

module sfr_cell #(
  parameter int IDX = 0,
  parameter int LW  = 4
) (
  input  wire logic               clk,
  input  wire sfr_pkg::cell_ctrl_t ctrl,
  input  wire sfr_pkg::byte_t     in_byte,
  input  wire logic               slot,       // this cell takes the new byte
  input  wire sfr_pkg::byte_t     pat_byte,
  input  wire logic [LW-1:0]      len,
  input  wire sfr_pkg::byte_t     neighbour,  // next cell's current byte
  output sfr_pkg::byte_t          cur,
  output logic                    hit
);
  import sfr_pkg::*;

  byte_t held;

  // The window as it stands once the new byte has been placed.
  assign cur = slot ? in_byte : held;
  assign hit = (LW'(IDX) >= len) || (cur == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      held <= ctrl.shift ? neighbour : cur;
    end
  end

endmodule

`default_nettype wire

### rtl/sfr_emit.sv
// sfr_emit: run buffer that shifts out the results of one input byte, one
// per cycle while the receiver does not stall, into the output register. Depends on sfr_pkg.
`default_nettype none

module sfr_emit #(
  parameter  int RUN_MAX = 8,
  localparam int CW      = $clog2(RUN_MAX + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire logic [RUN_MAX-1:0][7:0]  load_bytes,
  input  wire logic [CW-1:0]            load_cnt,
  input  wire sfr_pkg::run_flags_t      load_flags,
  output logic                          ready,
  output logic                          result_valid,
  output sfr_pkg::out_item_t            result,
  input  wire logic                     result_stall
);
  import sfr_pkg::*;

  logic [RUN_MAX-1:0][7:0] bytes;
  logic [CW-1:0]           cnt;
  run_flags_t              flags;
  logic                    move;

  assign move  = (cnt != '0) && (!result_valid || !result_stall);
  assign ready = (cnt == '0) || ((cnt == CW'(1)) && move);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= load_cnt;
      end else if (move) begin
        cnt <= cnt - CW'(1);
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= load_bytes;
      flags <= load_flags;
    end else if (move) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[RUN_MAX-1] <= '0;
    end
    if (move) begin
      result.out_byte      <= flags.marker ? 8'h00 : bytes[0];
      result.byte_valid    <= !flags.marker;
      result.last_of_run   <= (cnt == CW'(1));
      result.end_of_stream <= (cnt == CW'(1)) && flags.last;
      result.match_total   <= flags.total;
    end
  end

endmodule

`default_nettype wire

### rtl/stream_find_replace_top.sv
// stream_find_replace_top: streaming find-and-replace on a byte stream.
// Depends on sfr_pkg, sfr_cell and sfr_emit.
//
// Usage. Bytes arrive on the feed channel (feed_valid, feed_stall, feed);
// a transfer takes place on a rising edge with feed_valid high and
// feed_stall low. Results leave on the result channel in the same way.
// Each input byte yields zero to eight results: the oldest window byte
// when the window is full and does not match, the replacement bytes on a
// match, and on the byte marked stream_last the rest of the window, or a
// single end marker (byte_valid low) when that input yields nothing else.
// The first result of a byte passes through the run buffer and then the
// output register. Bytes that yield at most one result flow at one per
// cycle while the receiver does not stall; a byte that yields several
// results stalls the feed while the run buffer drains into the output
// register. The output register parts the two channels, so a byte is still
// taken while a result waits, as long as the run buffer is empty. When the
// receiver stalls, the result holds and the feed stalls once the run
// buffer cannot drain. Reset empties the window and the run buffer, clears
// the match count and loads the register reset values. Registers must be
// written over the APB port only while the block is idle, which the block
// does not enforce; a write to match_mode or pattern_length empties the window.
`default_nettype none

module stream_find_replace_top #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // feed channel
  input  wire logic                        feed_valid,
  output logic                             feed_stall,
  input  wire sfr_pkg::in_item_t           feed,
  // result channel
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output sfr_pkg::out_item_t               result,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0]  pwdata,
  output logic [sfr_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sfr_pkg::*;

  localparam int FW      = $clog2(PATTERN_MAX + 1);
  localparam int RW      = $clog2(REPLACE_MAX + 1);
  localparam int RUN_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CW      = $clog2(RUN_MAX + 1);

  // Configuration registers.
  logic [3:0]  match_mode;
  logic [3:0]  pattern_length;
  logic [63:0] pattern_bytes;
  logic [3:0]  replace_length;
  logic [63:0] replace_bytes;

  logic       cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode     <= MODE_LITERAL;
      pattern_length <= 4'd1;
      pattern_bytes  <= '0;
      replace_length <= 4'd0;
      replace_bytes  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MATCH_MODE:     match_mode     <= pwdata[3:0];
        REG_PATTERN_LENGTH: pattern_length <= pwdata[3:0];
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        REG_REPLACE_LENGTH: replace_length <= pwdata[3:0];
        REG_REPLACE_BYTES:  replace_bytes  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_MATCH_MODE:     prdata = {60'd0, match_mode};
      REG_PATTERN_LENGTH: prdata = {60'd0, pattern_length};
      REG_PATTERN_BYTES:  prdata = pattern_bytes;
      REG_REPLACE_LENGTH: prdata = {60'd0, replace_length};
      REG_REPLACE_BYTES:  prdata = replace_bytes;
      default:            prdata = '0;
    endcase
  end

  // Effective pattern and replacement lengths. Class modes test one byte;
  // out-of-range lengths are clamped.
  logic          is_class;
  logic [FW-1:0] len_eff;
  logic [RW-1:0] rep_len;

  always_comb begin
    is_class = match_mode inside {[MODE_BLANK:MODE_HIGH]};
    if (is_class || (pattern_length == 4'd0)) begin
      len_eff = FW'(1);
    end else if (pattern_length > 4'(PATTERN_MAX)) begin
      len_eff = FW'(PATTERN_MAX);
    end else begin
      len_eff = FW'(pattern_length);
    end
    if (replace_length > 4'(REPLACE_MAX)) begin
      rep_len = RW'(REPLACE_MAX);
    end else begin
      rep_len = RW'(replace_length);
    end
  end

  // Window: a row of cells. The new byte lands in the cell at the fill
  // position; on a full window without a match every cell takes its
  // neighbour's byte, dropping the oldest.
  logic [FW-1:0]  fill;
  logic [FW-1:0]  fill_inc;
  logic           accept;
  logic           full;
  logic           match;
  cell_ctrl_t     cell_ctrl;
  byte_t          cur [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;

  assign accept   = feed_valid && !feed_stall;
  assign fill_inc = fill + FW'(1);
  assign full     = (fill_inc == len_eff);
  assign match    = is_class ? class_hit(match_mode, cur[0]) : (&hit);

  assign cell_ctrl.accept = accept;
  assign cell_ctrl.shift  = full && !match;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    byte_t nb;
    if (i == PATTERN_MAX - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cur[i+1];
    end
    sfr_cell #(
      .IDX (i),
      .LW  (FW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .in_byte   (feed.in_byte),
      .slot      (fill == FW'(i)),
      .pat_byte  (pattern_bytes[8*i +: 8]),
      .len       (len_eff),
      .neighbour (nb),
      .cur       (cur[i]),
      .hit       (hit[i])
    );
  end

  // Fill count and saturating match counter.
  logic [FW-1:0] fill_next;
  logic [15:0]   match_counter;
  logic [15:0]   match_counter_next;

  always_comb begin
    fill_next          = fill;
    match_counter_next = match_counter;
    if (accept) begin
      if (feed.stream_last) begin
        fill_next = '0;
      end else if (full) begin
        fill_next = match ? '0 : (len_eff - FW'(1));
      end else begin
        fill_next = fill_inc;
      end
      if (full && match && (match_counter != 16'hFFFF)) begin
        match_counter_next = match_counter + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      match_counter <= '0;
    end else begin
      match_counter <= match_counter_next;
      if (cfg_write && ((cfg_index == REG_MATCH_MODE) ||
                        (cfg_index == REG_PATTERN_LENGTH))) begin
        fill <= '0;
      end else begin
        fill <= fill_next;
      end
    end
  end

  // Build the run of results for the byte being taken. It is either the
  // replacement string or the window itself, from its oldest byte.
  logic [RUN_MAX-1:0][7:0] run_bytes;
  logic [CW-1:0]           run_cnt;
  run_flags_t              run_flags;

  always_comb begin
    for (int i = 0; i < RUN_MAX; i++) begin
      run_bytes[i] = '0;
      if (full && match) begin
        if (i < REPLACE_MAX) begin
          run_bytes[i] = replace_bytes[8*i +: 8];
        end
      end else if (i < PATTERN_MAX) begin
        run_bytes[i] = cur[i];
      end
    end
    run_flags.marker = 1'b0;
    run_flags.last   = feed.stream_last;
    run_flags.total  = match_counter_next;
    if (full && match) begin
      if (feed.stream_last && (rep_len == '0)) begin
        // Final input that leaves nothing to send: one end marker.
        run_cnt          = CW'(1);
        run_flags.marker = 1'b1;
      end else begin
        run_cnt = CW'(rep_len);
      end
    end else if (full) begin
      run_cnt = feed.stream_last ? CW'(len_eff) : CW'(1);
    end else begin
      run_cnt = feed.stream_last ? CW'(fill_inc) : '0;
    end
  end

  logic emit_ready;

  assign feed_stall = !emit_ready;

  sfr_emit #(
    .RUN_MAX (RUN_MAX)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_bytes   (run_bytes),
    .load_cnt     (run_cnt),
    .load_flags   (run_flags),
    .ready        (emit_ready),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

### rtl/sfr_checker.sv
// sfr_checker: port-level checks on the result channel of the stream
// find-and-replace block, bound to the top level. Depends on sfr_pkg.
`default_nettype none

module sfr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire sfr_pkg::out_item_t result
);
  import sfr_pkg::*;

  // A result that closes the stream also closes its run.
  a_eos_closes_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_stream) |-> result.last_of_run)
    else $error("end_of_stream without last_of_run");

  // An end marker only ever closes the stream.
  a_marker_is_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.byte_valid) |->
      (result.last_of_run && result.end_of_stream && (result.out_byte == 8'h00)))
    else $error("end marker in the middle of a stream");

  // The match count never goes backwards between consecutive transfers.
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(rst) && $past(result_valid && !result_stall)) |->
      (result.match_total >= $past(result.match_total)))
    else $error("match_total decreased");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### verif/stream_find_replace_top_tb.sv
`timescale 1ns / 100ps
// stream_find_replace_top_tb: self-checking testbench for the stream find-and-replace block.
// Depends on sfr_pkg and stream_find_replace_top; a small scoreboard class predicts every result.

module stream_find_replace_top_tb;
  import sfr_pkg::*;

  localparam int SETTLE        = 8;       // cycles after the last result before the block is idle
  localparam int LIMIT         = 600000;  // run-away guard, in clock cycles
  localparam int HOLD_CYCLES   = 300;     // length of the long receiver hold-off
  localparam int RANDOM_ITEMS  = 100;
  localparam int REPORT_MAX    = 40;

  // The scoreboard keeps its own copy of the window, the match counter and the
  // registers. Every accepted input byte is turned into the run of results it
  // must cause, and those wait in order until the result channel delivers them.
  class sfr_scoreboard;
    byte_t       win [8];
    int unsigned fill;
    logic [15:0] match_count;
    logic [3:0]  mode;
    logic [3:0]  pat_len;
    logic [3:0]  rep_len;
    logic [63:0] pat;
    logic [63:0] rep;
    out_item_t   awaited [$];
    int          errors;

    function new();
      fill        = 0;
      match_count = '0;
      mode        = MODE_LITERAL;
      pat_len     = 4'd1;
      pat         = '0;
      rep_len     = 4'd0;
      rep         = '0;
      errors      = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [63:0] value);
      case (idx)
        REG_MATCH_MODE: begin
          mode = value[3:0];
          fill = 0;
        end
        REG_PATTERN_LENGTH: begin
          pat_len = value[3:0];
          fill    = 0;
        end
        REG_PATTERN_BYTES:  pat = value;
        REG_REPLACE_LENGTH: rep_len = value[3:0];
        REG_REPLACE_BYTES:  rep = value;
        default: ;
      endcase
    endfunction

    function bit class_select();
      return (mode >= MODE_BLANK) && (mode <= MODE_HIGH);
    endfunction

    // Number of window bytes that one match decision looks at.
    function int unsigned span();
      if (class_select()) return 1;
      if (pat_len == 4'd0) return 1;
      if (pat_len > 4'd8) return 8;
      return pat_len;
    endfunction

    function bit in_class(byte_t b);
      bit blank, digit, lower, upper, ascii;
      blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      lower = (b >= CH_LOW_A) && (b <= CH_LOW_Z);
      upper = (b >= CH_UP_A) && (b <= CH_UP_Z);
      ascii = blank || ((b > CH_SPACE) && (b < CH_HIGH));
      case (mode)
        MODE_BLANK:    return blank;
        MODE_DIGIT:    return digit;
        MODE_LETTER:   return lower || upper;
        MODE_LOWER:    return lower;
        MODE_UPPER:    return upper;
        MODE_ALNUM:    return lower || upper || digit;
        MODE_ASCII:    return ascii;
        MODE_NOTASCII: return !ascii;
        MODE_HIGH:     return b >= CH_HIGH;
        default:       return 1'b0;
      endcase
    endfunction

    function void note_input(in_item_t item);
      out_item_t   run [$];
      out_item_t   r;
      int unsigned len;
      int unsigned rl;
      bit          hit;
      len = span();
      if (fill >= len) fill = 0;
      win[fill] = item.in_byte;
      fill++;
      if (fill >= len) begin
        if (class_select()) begin
          hit = in_class(win[0]);
        end else begin
          hit = 1'b1;
          for (int i = 0; i < len; i++)
            if (win[i] != pat[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          if (match_count != 16'hFFFF) match_count++;
          rl = (rep_len > 4'd8) ? 8 : rep_len;
          for (int i = 0; i < rl; i++) begin
            r = '0;
            r.out_byte   = rep[8*i +: 8];
            r.byte_valid = 1'b1;
            run.push_back(r);
          end
          fill = 0;
        end else begin
          r = '0;
          r.out_byte   = win[0];
          r.byte_valid = 1'b1;
          run.push_back(r);
          for (int i = 0; i < 7; i++) win[i] = win[i+1];
          fill--;
        end
      end
      if (item.stream_last) begin
        for (int i = 0; i < fill; i++) begin
          r = '0;
          r.out_byte   = win[i];
          r.byte_valid = 1'b1;
          run.push_back(r);
        end
        fill = 0;
        // A closing byte that yields nothing still produces an end marker.
        if (run.size() == 0) run.push_back('0);
      end
      foreach (run[k]) run[k].match_total = match_count;
      if (run.size() > 0) begin
        run[run.size()-1].last_of_run   = 1'b1;
        run[run.size()-1].end_of_stream = item.stream_last;
      end
      foreach (run[k]) awaited.push_back(run[k]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: result with none expected: byte %h valid %b last %b eos %b total %0d",
                   $time, got.out_byte, got.byte_valid, got.last_of_run,
                   got.end_of_stream, got.match_total);
        return;
      end
      want = awaited.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.last_of_run !== want.last_of_run || got.end_of_stream !== want.end_of_stream ||
          got.match_total !== want.match_total) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"%0t: mismatch: expected byte %h valid %b last %b eos %b total %0d, ",
                    "actual byte %h valid %b last %b eos %b total %0d"}, $time,
                   want.out_byte, want.byte_valid, want.last_of_run, want.end_of_stream,
                   want.match_total, got.out_byte, got.byte_valid, got.last_of_run,
                   got.end_of_stream, got.match_total);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  // Block inputs are all given known values from time zero.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  feed_valid   = 1'b0;
  logic                  feed_stall;
  in_item_t              feed         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [ADDR_W-1:0]     paddr        = '0;
  logic [DATA_W-1:0]     pwdata       = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  sfr_scoreboard sb = new();
  in_item_t      stream_q [$];
  int            sender_idle_pct = 0;
  int            stall_pct       = 0;
  int            hold_requests   = 0;
  int            hold_served     = 0;
  int            hold_left       = 0;
  int            cycles          = 0;
  int            phase_no        = 0;
  int            rand_items      = 0;

  stream_find_replace_top dut (
    .clk          (clk),
    .rst          (rst),
    .feed_valid   (feed_valid),
    .feed_stall   (feed_stall),
    .feed         (feed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run-away guard: a correct run ends long before this count is reached.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, sb.outstanding());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before any register of the
  // block has moved, so each transfer is seen exactly as the block saw it.
  always @(posedge clk) begin
    if (!rst) begin
      if (feed_valid && !feed_stall) sb.note_input(feed);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // Receiver. It stalls at random at the rate of the current phase; when a
  // long hold-off has been asked for, it counts that stretch down itself and
  // keeps the result channel blocked throughout.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One register write: a setup phase, then an access phase that completes at
  // the edge where pready is seen high. The predictor follows at that edge.
  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one byte and holds it until the transfer takes place. Idle cycles
  // before it are drawn one at a time at the sender's idle rate.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      feed_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_valid <= 1'b1;
    feed       <= item;
    @(posedge clk);
    while (feed_stall) @(posedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_item(stream_q[i]);
    @(negedge clk);
    feed_valid <= 1'b0;
    stream_q.delete();
  endtask

  // The block counts as idle once every predicted result has come and a few
  // more cycles have passed for bytes that were still on their way through.
  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Idling rotates over the phases: none, sender idle, receiver stalling, both.
  task automatic next_phase();
    case (phase_no % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 76; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 76; end
      default: begin sender_idle_pct = 29; stall_pct = 29; end
    endcase
    phase_no++;
  endtask

  function automatic void add_byte(input byte_t b, input bit last);
    in_item_t item;
    item.in_byte     = b;
    item.stream_last = last;
    stream_q.push_back(item);
  endfunction

  // Bytes that sit on or near the edges of the character classes.
  function automatic byte_t class_byte();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return CH_SPACE;
          1: return CH_TAB;
          2: return CH_LF;
          default: return CH_CR;
        endcase
      end
      1: return byte_t'(CH_ZERO + $urandom_range(9));
      2: return byte_t'(CH_LOW_A + $urandom_range(25));
      3: return byte_t'(CH_UP_A + $urandom_range(25));
      4: return byte_t'(CH_HIGH + $urandom_range(127));
      5: return byte_t'($urandom_range(8'h1F));
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // A random stream. In literal mode most of it is copies and fragments of the
  // pattern, so that matches, near misses and overlaps are common; in class
  // mode bytes near the class edges dominate. The rest is plain noise.
  task automatic build_random(input int n);
    int unsigned len;
    int          r;
    len = sb.span();
    while (stream_q.size() < n) begin
      r = $urandom_range(99);
      if (!sb.class_select() && r < 40) begin
        for (int i = 0; i < len; i++) add_byte(sb.pat[8*i +: 8], 1'b0);
      end else if (!sb.class_select() && r < 70) begin
        add_byte(sb.pat[8*$urandom_range(len-1) +: 8], 1'b0);
      end else if (sb.class_select() && r < 60) begin
        add_byte(class_byte(), 1'b0);
      end else begin
        add_byte(byte_t'($urandom_range(255)), $urandom_range(99) < 4);
      end
    end
    if ($urandom_range(99) < 80) stream_q[stream_q.size()-1].stream_last = 1'b1;
  endtask

  // Each register is rewritten with some chance; the first random phase
  // rewrites all of them.
  task automatic random_config(input bit all_regs);
    int r;
    r = $urandom_range(99);
    if (all_regs || $urandom_range(99) < 60) begin
      if (r < 45)      write_reg(REG_MATCH_MODE, MODE_LITERAL);
      else if (r < 55) write_reg(REG_MATCH_MODE, $urandom_range(10, 15));
      else             write_reg(REG_MATCH_MODE, $urandom_range(1, 9));
    end
    if (all_regs || $urandom_range(99) < 60)
      write_reg(REG_PATTERN_LENGTH, ($urandom_range(99) < 80) ? $urandom_range(1, 4)
                                                            : $urandom_range(15));
    if (all_regs || $urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 10)      write_reg(REG_PATTERN_BYTES, '0);
      else if (r < 20) write_reg(REG_PATTERN_BYTES, '1);
      else             write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
    end
    if (all_regs || $urandom_range(99) < 60)
      write_reg(REG_REPLACE_LENGTH, $urandom_range(15));
    if (all_regs || $urandom_range(99) < 60)
      write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a one-byte pattern of zero with an empty replacement,
    // so zero bytes are deleted. The closing byte is itself deleted with
    // nothing left in the window, which leaves only the end marker.
    next_phase();
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    send_stream();

    // Widest pattern of all ones, pattern and replacement lengths beyond their
    // maxima, and a full eight-byte replacement run.
    wait_idle();
    write_reg(REG_MATCH_MODE, MODE_LITERAL);
    write_reg(REG_PATTERN_LENGTH, 4'd15);
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_REPLACE_LENGTH, 4'd15);
    write_reg(REG_REPLACE_BYTES, 64'h0123_4567_89AB_CDEF);
    next_phase();
    repeat (8) add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    send_stream();

    // Mode code above the last class falls back to literal; a pattern length
    // of zero behaves as one.
    wait_idle();
    write_reg(REG_MATCH_MODE, 4'd15);
    write_reg(REG_PATTERN_LENGTH, 4'd0);
    write_reg(REG_PATTERN_BYTES, 64'h41);
    write_reg(REG_REPLACE_LENGTH, 4'd8);
    write_reg(REG_REPLACE_BYTES, 64'hFEDC_BA98_7654_3210);
    next_phase();
    add_byte(CH_UP_A, 1'b0);
    add_byte(8'h42, 1'b1);
    send_stream();

    // Two bytes of a three-byte pattern wait in the window; shortening the
    // pattern then throws them away, so only the closing byte comes out.
    wait_idle();
    write_reg(REG_MATCH_MODE, MODE_LITERAL);
    write_reg(REG_PATTERN_LENGTH, 4'd3);
    write_reg(REG_PATTERN_BYTES, 64'h63_6261);
    next_phase();
    add_byte(CH_LOW_A, 1'b0);
    add_byte(8'h62, 1'b0);
    send_stream();
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 4'd2);
    add_byte(8'h63, 1'b1);
    send_stream();

    // Every character class once, each with a byte that belongs to it.
    wait_idle();
    write_reg(REG_REPLACE_LENGTH, 4'd1);
    write_reg(REG_REPLACE_BYTES, 64'h2A);
    for (int m = MODE_BLANK; m <= MODE_HIGH; m++) begin
      wait_idle();
      write_reg(REG_MATCH_MODE, m);
      next_phase();
      case (m)
        MODE_BLANK:    add_byte(CH_TAB, 1'b1);
        MODE_DIGIT:    add_byte(CH_NINE, 1'b1);
        MODE_LETTER:   add_byte(CH_UP_Z, 1'b1);
        MODE_LOWER:    add_byte(CH_LOW_A, 1'b1);
        MODE_UPPER:    add_byte(CH_UP_A, 1'b1);
        MODE_ALNUM:    add_byte(CH_ZERO, 1'b1);
        MODE_ASCII:    add_byte(8'h7F, 1'b1);
        MODE_NOTASCII: add_byte(8'h1F, 1'b1);
        default:       add_byte(8'hFF, 1'b1);
      endcase
      send_stream();
    end

    // Back-pressure: most bytes match and expand to eight, and the receiver
    // holds off for a long stretch while the sender keeps offering, so the
    // block fills up and stalls its feed.
    wait_idle();
    write_reg(REG_MATCH_MODE, MODE_LITERAL);
    write_reg(REG_PATTERN_LENGTH, 4'd1);
    write_reg(REG_PATTERN_BYTES, 64'h78);
    write_reg(REG_REPLACE_LENGTH, 4'd8);
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_requests++;
    for (int i = 0; i < 24; i++) add_byte((i % 5 == 3) ? 8'h79 : 8'h78, i == 23);
    rand_items += stream_q.size();
    send_stream();

    // Random phases. Each starts from an idle block, so the sender also pauses
    // until every result of the previous phase has arrived.
    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      random_config(rand_items == 24);
      next_phase();
      build_random($urandom_range(4, 16));
      rand_items += stream_q.size();
      send_stream();
    end

    // Letter class with a two-byte replacement: matches, a digit that passes
    // through, and a closing match.
    wait_idle();
    write_reg(REG_MATCH_MODE, MODE_LETTER);
    write_reg(REG_REPLACE_LENGTH, 4'd2);
    phase_no = 3;
    next_phase();
    add_byte(8'h62, 1'b0);
    add_byte(CH_NINE, 1'b0);
    add_byte(8'h63, 1'b1);
    send_stream();

    // Drain, then give stray results a chance to show up before the verdict.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
